/* sv/radix_convert_custom_alphabet_assert.svh */
// Assertion macros for the radix converter, sampled on i_clk and disabled in reset
`ifndef RADIX_CONVERT_CUSTOM_ALPHABET_ASSERT_SVH
`define RADIX_CONVERT_CUSTOM_ALPHABET_ASSERT_SVH

// Check a property on every clock edge outside reset
`define RCCA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger
`define RCCA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/rcca_pkg.sv */
// Shared types, constants and helper functions for the radix converter
package rcca_pkg;

    typedef logic [7:0] t_char;

    localparam int unsigned MAX_BASE   = 16;
    localparam int unsigned DIGIT_W    = 4;
    localparam int unsigned BASE_W     = 5;
    localparam int unsigned APB_ADDR_W = 6;
    localparam int unsigned APB_DATA_W = 64;

    localparam t_char CHAR_PLUS  = 8'h2B;
    localparam t_char CHAR_MINUS = 8'h2D;

    // Register indexes (byte address divided by eight)
    localparam logic [2:0] REG_FROM_BASE = 3'd0;
    localparam logic [2:0] REG_TO_BASE   = 3'd1;
    localparam logic [2:0] REG_FROM_LO   = 3'd2;
    localparam logic [2:0] REG_FROM_HI   = 3'd3;
    localparam logic [2:0] REG_TO_LO     = 3'd4;
    localparam logic [2:0] REG_TO_HI     = 3'd5;

    typedef logic [BASE_W-1:0] t_base;

    // Limit a configured base size to the supported range
    function automatic t_base clamp_base(input t_base b);
        t_base res;
        if (b < t_base'(2)) begin
            res = t_base'(2);
        end else if (b > t_base'(MAX_BASE)) begin
            res = t_base'(MAX_BASE);
        end else begin
            res = b;
        end
        return res;
    endfunction

    // Pick one byte-wide symbol out of the two alphabet words
    function automatic t_char sym_at(input logic [63:0] lo, input logic [63:0] hi,
                                     input logic [DIGIT_W-1:0] idx);
        logic [127:0] w;
        w = {hi, lo};
        return w[{idx, 3'b000} +: 8];
    endfunction

endpackage

/* sv/rcca_in_if.sv */
// Input character channel: valid/ready with one character and a last marker
interface rcca_in_if;
    import rcca_pkg::*;

    logic  valid;
    logic  ready;
    t_char char_code;
    logic  is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

/* sv/rcca_out_if.sv */
// Output character channel: valid/ready with one character, last marker and flags
interface rcca_out_if;
    import rcca_pkg::*;

    logic  valid;
    logic  ready;
    t_char out_char;
    logic  out_last;
    logic  invalid_seen;
    logic  overflow;

    modport source (output valid, output out_char, output out_last, output invalid_seen,
                    output overflow, input ready);
    modport sink   (input valid, input out_char, input out_last, input invalid_seen,
                    input overflow, output ready);
endinterface

/* sv/radix_convert_custom_alphabet.sv */
// Sequence: a sign character is taken in ST_IDLE alone, any other character also passes ST_MAC;
// after the final one the bit-serial divider runs once per output digit (one quotient bit a
// cycle), then ST_EMIT sends one output char a cycle while o_out.ready is high.
// Throughput: one request at a time; the restoring divider sets the conversion time.
// Reset: synchronous active-low i_rst_n clears the number state and loads register defaults.
`include "radix_convert_custom_alphabet_assert.svh"

module radix_convert_custom_alphabet #(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    rcca_in_if.sink                            i_in,
    rcca_out_if.source                         o_out,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rcca_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [rcca_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [rcca_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import rcca_pkg::*;

    localparam int unsigned MW    = VALUE_WIDTH - 1;
    localparam int unsigned PW    = MW + BASE_W;
    localparam int unsigned CNT_W = $clog2(VALUE_WIDTH + 1);
    localparam int unsigned BIT_W = $clog2(MW);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MAC  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    // Configuration registers
    t_base       r_from_base, r_to_base;
    logic [63:0] r_from_lo, r_from_hi, r_to_lo, r_to_hi;

    // Control state
    logic [1:0]       r_state, n_state;
    logic [MW-1:0]    r_mag, n_mag;
    logic             r_neg, n_neg;
    logic             r_first, n_first;
    logic             r_bad, n_bad;
    logic             r_sat, n_sat;
    logic             r_last, n_last;
    logic [BIT_W-1:0] r_bit, n_bit;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_sgn_pend, n_sgn_pend;
    logic             r_ovalid, n_ovalid;

    // Datapath registers
    logic               r_found, n_found;
    logic [DIGIT_W-1:0] r_digit, n_digit;
    logic [MW-1:0]      r_quo, n_quo;
    logic [DIGIT_W-1:0] r_rem, n_rem;
    logic [DIGIT_W-1:0] r_stk [VALUE_WIDTH];
    logic [DIGIT_W-1:0] n_stk [VALUE_WIDTH];
    t_char              r_och, n_och;
    logic               r_olast, n_olast;
    logic               r_oinv, n_oinv;
    logic               r_oovf, n_oovf;

    // Combinational helpers
    t_base              c_fb, c_tb;
    logic               c_hit;
    logic [DIGIT_W-1:0] c_idx;
    logic               c_is_sign;
    logic [PW-1:0]      c_prod;
    logic [MW-1:0]      c_mag_new;
    logic               c_sat_new;
    logic [BASE_W-1:0]  c_rem_sh;
    logic               c_ge;
    logic [BASE_W-1:0]  c_rem_sub;
    logic [MW-1:0]      c_quo_new;
    logic               c_out_free;
    logic               c_apb_wr;
    logic               c_div_end;

    assign c_fb = clamp_base(r_from_base);
    assign c_tb = clamp_base(r_to_base);

    // Look up the incoming character in the source alphabet, lowest index wins
    always_comb begin
        c_hit = 1'b0;
        c_idx = '0;
        for (int j = MAX_BASE - 1; j >= 0; j--) begin
            if ((t_base'(j) < c_fb) &&
                (sym_at(r_from_lo, r_from_hi, DIGIT_W'(j)) == i_in.char_code)) begin
                c_hit = 1'b1;
                c_idx = DIGIT_W'(j);
            end
        end
    end

    assign c_is_sign = r_first &&
                       ((i_in.char_code == CHAR_PLUS) || (i_in.char_code == CHAR_MINUS));

    // Multiply-accumulate with saturation at the largest magnitude
    assign c_prod    = PW'(r_mag) * PW'(c_fb) + PW'(r_digit);
    assign c_sat_new = (c_prod[PW-1:MW] != '0);
    assign c_mag_new = c_sat_new ? {MW{1'b1}} : c_prod[MW-1:0];

    // One restoring division step by the target base
    assign c_rem_sh  = {r_rem, r_quo[MW-1]};
    assign c_ge      = (c_rem_sh >= c_tb);
    assign c_rem_sub = c_ge ? (c_rem_sh - c_tb) : c_rem_sh;
    assign c_quo_new = {r_quo[MW-2:0], c_ge};

    assign c_out_free = !r_ovalid || o_out.ready;

    // Last step of one division
    assign c_div_end = (r_state == ST_DIV) && (r_bit == BIT_W'(MW - 1));

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_mag      = r_mag;
        n_neg      = r_neg;
        n_first    = r_first;
        n_bad      = r_bad;
        n_sat      = r_sat;
        n_last     = r_last;
        n_bit      = r_bit;
        n_cnt      = r_cnt;
        n_sgn_pend = r_sgn_pend;
        n_ovalid   = r_ovalid && !o_out.ready;
        n_found    = r_found;
        n_digit    = r_digit;
        n_quo      = r_quo;
        n_rem      = r_rem;
        n_stk      = r_stk;
        n_och      = r_och;
        n_olast    = r_olast;
        n_oinv     = r_oinv;
        n_oovf     = r_oovf;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_first = 1'b0;
                    n_last  = i_in.is_last;
                    if (c_is_sign) begin
                        n_neg = (i_in.char_code == CHAR_MINUS);
                        if (i_in.is_last) begin
                            n_quo   = r_mag;
                            n_rem   = '0;
                            n_bit   = '0;
                            n_cnt   = '0;
                            n_state = ST_DIV;
                        end
                    end else begin
                        n_found = c_hit;
                        n_digit = c_idx;
                        n_state = ST_MAC;
                    end
                end
            end
            ST_MAC: begin
                if (r_found) begin
                    n_mag = c_mag_new;
                    n_sat = r_sat || c_sat_new;
                end else begin
                    n_bad = 1'b1;
                end
                if (r_last) begin
                    n_quo   = r_found ? c_mag_new : r_mag;
                    n_rem   = '0;
                    n_bit   = '0;
                    n_cnt   = '0;
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_DIV: begin
                n_quo = c_quo_new;
                n_rem = c_rem_sub[DIGIT_W-1:0];
                n_bit = r_bit + BIT_W'(1);
                // Push the remainder digit at the end of each division
                if (r_bit == BIT_W'(MW - 1)) begin
                    n_stk[0] = c_rem_sub[DIGIT_W-1:0];
                    for (int i = VALUE_WIDTH - 1; i >= 1; i--) begin
                        n_stk[i] = r_stk[i-1];
                    end
                    n_cnt = r_cnt + CNT_W'(1);
                    n_rem = '0;
                    n_bit = '0;
                    if (c_quo_new == '0) begin
                        n_sgn_pend = r_neg;
                        n_state    = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (c_out_free) begin
                    n_ovalid = 1'b1;
                    n_oinv   = r_bad;
                    n_oovf   = r_sat;
                    if (r_sgn_pend) begin
                        n_och      = CHAR_MINUS;
                        n_olast    = 1'b0;
                        n_sgn_pend = 1'b0;
                    end else begin
                        // Pop the most significant digit
                        n_och   = sym_at(r_to_lo, r_to_hi, r_stk[0]);
                        n_olast = (r_cnt == CNT_W'(1));
                        for (int i = 0; i < VALUE_WIDTH - 1; i++) begin
                            n_stk[i] = r_stk[i+1];
                        end
                        n_cnt = r_cnt - CNT_W'(1);
                        if (r_cnt == CNT_W'(1)) begin
                            n_mag   = '0;
                            n_neg   = 1'b0;
                            n_first = 1'b1;
                            n_bad   = 1'b0;
                            n_sat   = 1'b0;
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_mag      <= '0;
            r_neg      <= 1'b0;
            r_first    <= 1'b1;
            r_bad      <= 1'b0;
            r_sat      <= 1'b0;
            r_last     <= 1'b0;
            r_bit      <= '0;
            r_cnt      <= '0;
            r_sgn_pend <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_mag      <= n_mag;
            r_neg      <= n_neg;
            r_first    <= n_first;
            r_bad      <= n_bad;
            r_sat      <= n_sat;
            r_last     <= n_last;
            r_bit      <= n_bit;
            r_cnt      <= n_cnt;
            r_sgn_pend <= n_sgn_pend;
            r_ovalid   <= n_ovalid;
        end
    end

    // Advance the datapath
    always_ff @(posedge i_clk) begin
        r_found <= n_found;
        r_digit <= n_digit;
        r_quo   <= n_quo;
        r_rem   <= n_rem;
        r_stk   <= n_stk;
        r_och   <= n_och;
        r_olast <= n_olast;
        r_oinv  <= n_oinv;
        r_oovf  <= n_oovf;
    end

    // Drive the channels
    assign i_in.ready         = (r_state == ST_IDLE);
    assign o_out.valid        = r_ovalid;
    assign o_out.out_char     = r_och;
    assign o_out.out_last     = r_olast;
    assign o_out.invalid_seen = r_oinv;
    assign o_out.overflow     = r_oovf;

    // Write configuration registers on the access phase
    assign c_apb_wr = psel && penable && pwrite;
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_from_base <= t_base'(10);
            r_to_base   <= t_base'(16);
            r_from_lo   <= '0;
            r_from_hi   <= '0;
            r_to_lo     <= '0;
            r_to_hi     <= '0;
        end else if (c_apb_wr) begin
            unique case (paddr[5:3])
                REG_FROM_BASE: r_from_base <= pwdata[BASE_W-1:0];
                REG_TO_BASE:   r_to_base   <= pwdata[BASE_W-1:0];
                REG_FROM_LO:   r_from_lo   <= pwdata;
                REG_FROM_HI:   r_from_hi   <= pwdata;
                REG_TO_LO:     r_to_lo     <= pwdata;
                REG_TO_HI:     r_to_hi     <= pwdata;
                default: ;
            endcase
        end
    end

    // Read back configuration registers
    always_comb begin
        unique case (paddr[5:3])
            REG_FROM_BASE: prdata = APB_DATA_W'(r_from_base);
            REG_TO_BASE:   prdata = APB_DATA_W'(r_to_base);
            REG_FROM_LO:   prdata = r_from_lo;
            REG_FROM_HI:   prdata = r_from_hi;
            REG_TO_LO:     prdata = r_to_lo;
            REG_TO_HI:     prdata = r_to_hi;
            default:       prdata = '0;
        endcase
    end

    // Assertions
    `RCCA_ASSERT(a_cnt_bound, r_cnt <= CNT_W'(MW), "digit stack over-filled")
    `RCCA_ASSERT(a_sat_max, r_sat |-> (&r_mag), "saturated flag without maximum magnitude")
    `RCCA_ASSERT(a_emit_digits, (r_state == ST_EMIT) |-> (r_cnt != '0), "emit with empty stack")
    `RCCA_ASSERT_NEXT(a_div_push, c_div_end, r_cnt == $past(r_cnt) + CNT_W'(1), "digit not pushed")

endmodule
